### design/sbm_pkg.sv
// Shared types, codes and tables for the servo bus master transaction block.
package sbm_pkg;

  // Hunt reads allowed after a first byte that is not a header byte
  localparam int unsigned HUNT_EXTRA_READS_DEF = 6;

  // Request op codes
  localparam logic [2:0] OP_PING  = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_RX    = 3'd3;
  localparam logic [2:0] OP_RX_NONE = 3'd4;

  // Command kinds as kept in the command register
  localparam logic [1:0] KIND_PING  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // Link status codes
  localparam logic [2:0] LS_OK         = 3'd0;
  localparam logic [2:0] LS_BAD_PORT   = 3'd1;
  localparam logic [2:0] LS_NO_HEADER  = 3'd2;
  localparam logic [2:0] LS_BAD_HEADER = 3'd3;
  localparam logic [2:0] LS_BAD_CKSUM  = 3'd4;

  // Result kinds
  localparam logic RES_TX   = 1'b0;
  localparam logic RES_DONE = 1'b1;

  // Packet bytes
  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [7:0] INSTR_PING  = 8'h01;
  localparam logic [7:0] INSTR_READ  = 8'h02;
  localparam logic [7:0] INSTR_WRITE = 8'h03;
  localparam logic [7:0] LEN_PING    = 8'h02;
  localparam logic [7:0] LEN_READ    = 8'h04;
  localparam logic [7:0] LEN_WRITE1  = 8'h04;
  localparam logic [7:0] LEN_WRITE2  = 8'h05;

  // Status packet lengths
  localparam logic [3:0] STAT_LEN_BASE = 4'd6;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_WAIT = 4'b0010,
    PH_HUNT = 4'b0100,
    PH_FILL = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  id;
    logic [7:0]  address;
    logic [15:0] value;
    logic        two_bytes;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_beat_t;

  // Control table addresses that hold 16-bit operands
  function automatic logic wide_address(input logic [7:0] a);
    logic r;
    r = 1'b0;
    case (a) inside
      8'd0, 8'd6, 8'd8, 8'd14, 8'd20, 8'd22, 8'd30,
      8'd32, 8'd34, 8'd36, 8'd38, 8'd40, 8'd48: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### design/sbm_tx_frame.sv
// Instruction packet byte generator: picks the byte at a given packet position.
module sbm_tx_frame (
  input  sbm_pkg::cmd_t     cmd_i,
  input  logic [3:0]        idx_i,
  output sbm_pkg::tx_beat_t beat_o
);

  logic [7:0] len_b;
  logic [7:0] instr_b;
  logic [7:0] p6_b;
  logic [7:0] hi_b;
  logic [7:0] sum;
  logic [7:0] cks;
  logic [3:0] last_idx;
  logic       is_ping;
  logic       is_read;
  logic       has_hi;

  always_comb begin
    is_ping = (cmd_i.kind == sbm_pkg::KIND_PING);
    is_read = (cmd_i.kind == sbm_pkg::KIND_READ);
    has_hi  = !is_ping && !is_read && cmd_i.two_bytes;
    hi_b    = cmd_i.value[15:8];

    if (is_ping) begin
      len_b    = sbm_pkg::LEN_PING;
      instr_b  = sbm_pkg::INSTR_PING;
      last_idx = 4'd5;
    end else if (is_read) begin
      len_b    = sbm_pkg::LEN_READ;
      instr_b  = sbm_pkg::INSTR_READ;
      last_idx = 4'd7;
    end else begin
      len_b    = cmd_i.two_bytes ? sbm_pkg::LEN_WRITE2 : sbm_pkg::LEN_WRITE1;
      instr_b  = sbm_pkg::INSTR_WRITE;
      last_idx = cmd_i.two_bytes ? 4'd8 : 4'd7;
    end

    // read carries the operand size, write the low value byte
    p6_b = is_read ? (cmd_i.two_bytes ? 8'd2 : 8'd1) : cmd_i.value[7:0];

    sum = cmd_i.id + len_b + instr_b;
    if (!is_ping) sum = sum + cmd_i.address + p6_b;
    if (has_hi)   sum = sum + hi_b;
    cks = ~sum;

    case (idx_i)
      4'd0, 4'd1: beat_o.data = sbm_pkg::SYNC_BYTE;
      4'd2:       beat_o.data = cmd_i.id;
      4'd3:       beat_o.data = len_b;
      4'd4:       beat_o.data = instr_b;
      4'd5:       beat_o.data = is_ping ? cks : cmd_i.address;
      4'd6:       beat_o.data = p6_b;
      4'd7:       beat_o.data = has_hi ? hi_b : cks;
      4'd8:       beat_o.data = cks;
      default:    beat_o.data = 8'h00;
    endcase
    beat_o.last = (idx_i == last_idx);
  end

endmodule

### design/servo_bus_master_transaction.sv
// Servo bus master transaction: instruction packet framing and status packet parsing.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------------
//   in      | request in| in_valid_i / in_stall_o| op, port_number, servo_id, reg_address,
//           |           |                        | write_value, rx_byte
//   out     | result out| out_valid_o/out_stall_i| kind, tx_byte, line_select, last,
//           |           |                        | link_status, servo_error, read_value
//
// Timing: a request is decoded in the cycle it is accepted and its results go
//   to the output register at that edge. A command (or a request that
//   triggers the retry) holds in_stall_o while its 6 to 9 packet bytes leave
//   one per cycle, unless out_stall_i holds them, from the output stage,
//   which is the single result port.
// The next request is taken in the same cycle its predecessor's last result
//   is taken, so back-to-back traffic sees no bubble.
// Reset (rst_ni low, asynchronous) returns the parser to idle, clears the
//   command and status registers and empties the output stage.
// out_stall_i holds the current result steady; input stalls only while the
//   output stage still has results of an earlier request to deliver.
module servo_bus_master_transaction #(
  parameter int unsigned HUNT_EXTRA_READS = sbm_pkg::HUNT_EXTRA_READS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [2:0]  port_number_i,
  input  logic [7:0]  servo_id_i,
  input  logic [7:0]  reg_address_i,
  input  logic [15:0] write_value_i,
  input  logic [7:0]  rx_byte_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [2:0]  line_select_o,
  output logic        last_o,
  output logic [2:0]  link_status_o,
  output logic [7:0]  servo_error_o,
  output logic [15:0] read_value_o
);

  localparam int unsigned HCW = $clog2(HUNT_EXTRA_READS + 1);
  localparam logic [HCW-1:0] HUNT_LIMIT = HCW'(HUNT_EXTRA_READS);

  // ---------------------------------------------------------------------------
  // Transaction state
  // ---------------------------------------------------------------------------
  sbm_pkg::phase_e phase_q, phase_d;
  sbm_pkg::cmd_t   cmd_q, cmd_d;
  logic [2:0]      line_q, line_d;
  logic            second_q, second_d;
  logic [HCW-1:0]  hunt_q, hunt_d;
  logic [3:0]      bidx_q, bidx_d;
  // only status bytes 2..6 are ever looked at again
  logic [7:0]      resp_q [2:6];
  logic [7:0]      resp_d [2:6];
  logic [7:0]      resp_w [2:6];

  // ---------------------------------------------------------------------------
  // Output stage
  // ---------------------------------------------------------------------------
  logic            busy_q, busy_d;
  logic            fin_q, fin_d;
  logic [3:0]      idx_q, idx_d;
  logic [2:0]      fst_q, fst_d;
  logic [7:0]      ferr_q, ferr_d;
  logic [15:0]     fval_q, fval_d;

  sbm_pkg::tx_beat_t beat;

  logic            accept;
  logic            take;
  logic            last_now;

  // decode scratch
  logic            got;
  logic [7:0]      v;
  logic [3:0]      stat_len;
  logic [3:0]      bidx_inc;
  logic [HCW-1:0]  hunt_inc;
  logic [7:0]      sum;
  logic            end_att;
  logic [2:0]      end_status;
  logic            start_att;
  logic            emit_pkt;
  logic            emit_fin;
  logic [2:0]      fin_status;
  logic [7:0]      fin_err;
  logic [15:0]     fin_val;

  sbm_tx_frame u_frame (
    .cmd_i  (cmd_q),
    .idx_i  (idx_q),
    .beat_o (beat)
  );

  assign take       = busy_q && !out_stall_i;
  assign last_now   = fin_q || beat.last;
  assign in_stall_o = busy_q && !(take && last_now);
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Request decode and parser step
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_d    = phase_q;
    cmd_d      = cmd_q;
    line_d     = line_q;
    second_d   = second_q;
    hunt_d     = hunt_q;
    bidx_d     = bidx_q;
    resp_w     = resp_q;
    end_att    = 1'b0;
    end_status = sbm_pkg::LS_OK;
    start_att  = 1'b0;
    emit_pkt   = 1'b0;
    emit_fin   = 1'b0;
    fin_status = sbm_pkg::LS_OK;
    fin_err    = 8'h00;
    fin_val    = 16'h0000;

    got      = (op_i == sbm_pkg::OP_RX);
    v        = got ? rx_byte_i : sbm_pkg::SYNC_BYTE;  // missed read fills as FF
    stat_len = (cmd_q.kind == sbm_pkg::KIND_READ)
               ? (cmd_q.two_bytes ? 4'd8 : 4'd7) : sbm_pkg::STAT_LEN_BASE;
    bidx_inc = bidx_q + 4'd1;
    hunt_inc = hunt_q + HCW'(1);

    // checksum over status bytes 2 .. len-2, all stored before the last byte
    sum = resp_q[2] + resp_q[3] + resp_q[4];
    if (stat_len >= 4'd7) sum = sum + resp_q[5];
    if (stat_len >= 4'd8) sum = sum + resp_q[6];

    if (accept) begin
      if (op_i <= sbm_pkg::OP_WRITE) begin
        cmd_d.kind      = op_i[1:0];
        cmd_d.id        = servo_id_i;
        cmd_d.address   = reg_address_i;
        cmd_d.value     = write_value_i;
        cmd_d.two_bytes = sbm_pkg::wide_address(reg_address_i);
        second_d        = 1'b0;
        start_att       = 1'b1;
        if (!(port_number_i inside {[3'd1:3'd4]})) begin
          line_d     = 3'd0;
          emit_fin   = 1'b1;
          fin_status = sbm_pkg::LS_BAD_PORT;
        end else begin
          line_d   = port_number_i;
          emit_pkt = 1'b1;
        end
      end else if (op_i <= sbm_pkg::OP_RX_NONE && phase_q != sbm_pkg::PH_IDLE) begin
        case (phase_q)
          sbm_pkg::PH_WAIT: begin
            if (got) begin
              if (rx_byte_i == sbm_pkg::SYNC_BYTE) begin
                bidx_d  = 4'd1;
                phase_d = sbm_pkg::PH_FILL;
              end else begin
                hunt_d  = '0;
                phase_d = sbm_pkg::PH_HUNT;
              end
            end
          end
          sbm_pkg::PH_HUNT: begin
            hunt_d = hunt_inc;
            if (got && rx_byte_i == sbm_pkg::SYNC_BYTE) begin
              bidx_d  = 4'd1;
              phase_d = sbm_pkg::PH_FILL;
            end else if (hunt_inc >= HUNT_LIMIT) begin
              end_att    = 1'b1;
              end_status = sbm_pkg::LS_NO_HEADER;
            end
          end
          sbm_pkg::PH_FILL: begin
            for (int k = 2; k <= 6; k++) begin
              if (bidx_q == 4'(k)) resp_w[k] = v;
            end
            if (bidx_q == 4'd1 && v != sbm_pkg::SYNC_BYTE) begin
              end_att    = 1'b1;
              end_status = sbm_pkg::LS_BAD_HEADER;
            end else begin
              bidx_d = bidx_inc;
              if (bidx_inc == stat_len) begin
                end_att    = 1'b1;
                end_status = (~sum == v) ? sbm_pkg::LS_OK : sbm_pkg::LS_BAD_CKSUM;
              end
            end
          end
          default: ;
        endcase
      end

      if (end_att) begin
        if ((end_status != sbm_pkg::LS_OK || resp_w[4] != 8'h00) && !second_q) begin
          // one retry: resend the same packet
          second_d  = 1'b1;
          start_att = 1'b1;
          emit_pkt  = 1'b1;
        end else begin
          emit_fin   = 1'b1;
          fin_status = end_status;
          fin_err    = (end_status == sbm_pkg::LS_OK) ? resp_w[4] : 8'h00;
          if (cmd_q.kind == sbm_pkg::KIND_READ) begin
            fin_val = {cmd_q.two_bytes ? resp_w[6] : 8'h00, resp_w[5]};
          end
          phase_d = sbm_pkg::PH_IDLE;
        end
      end

      if (start_att) begin
        hunt_d  = '0;
        bidx_d  = 4'd0;
        phase_d = emit_fin ? sbm_pkg::PH_IDLE : sbm_pkg::PH_WAIT;
      end
    end

    for (int k = 2; k <= 6; k++) begin
      resp_d[k] = start_att ? 8'h00 : resp_w[k];
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage control
  // ---------------------------------------------------------------------------
  always_comb begin
    busy_d = busy_q;
    fin_d  = fin_q;
    idx_d  = idx_q;
    fst_d  = fst_q;
    ferr_d = ferr_q;
    fval_d = fval_q;

    if (take) begin
      if (last_now) busy_d = 1'b0;
      else          idx_d  = idx_q + 4'd1;
    end

    if (emit_pkt) begin
      busy_d = 1'b1;
      fin_d  = 1'b0;
      idx_d  = 4'd0;
    end else if (emit_fin) begin
      busy_d = 1'b1;
      fin_d  = 1'b1;
      fst_d  = fin_status;
      ferr_d = fin_err;
      fval_d = fin_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= sbm_pkg::PH_IDLE;
      cmd_q    <= '0;
      line_q   <= 3'd0;
      second_q <= 1'b0;
      hunt_q   <= '0;
      bidx_q   <= 4'd0;
      for (int k = 2; k <= 6; k++) resp_q[k] <= 8'h00;
      busy_q   <= 1'b0;
      fin_q    <= 1'b0;
      idx_q    <= 4'd0;
    end else begin
      phase_q  <= phase_d;
      cmd_q    <= cmd_d;
      line_q   <= line_d;
      second_q <= second_d;
      hunt_q   <= hunt_d;
      bidx_q   <= bidx_d;
      for (int k = 2; k <= 6; k++) resp_q[k] <= resp_d[k];
      busy_q   <= busy_d;
      fin_q    <= fin_d;
      idx_q    <= idx_d;
    end
  end

  // finish payload, no reset needed
  always_ff @(posedge clk_i) begin
    fst_q  <= fst_d;
    ferr_q <= ferr_d;
    fval_q <= fval_d;
  end

  // ---------------------------------------------------------------------------
  // Result ports
  // ---------------------------------------------------------------------------
  assign out_valid_o   = busy_q;
  assign kind_o        = fin_q ? sbm_pkg::RES_DONE : sbm_pkg::RES_TX;
  assign tx_byte_o     = fin_q ? 8'h00 : beat.data;
  assign line_select_o = line_q;
  assign last_o        = last_now;
  assign link_status_o = fin_q ? fst_q : sbm_pkg::LS_OK;
  assign servo_error_o = fin_q ? ferr_q : 8'h00;
  assign read_value_o  = fin_q ? fval_q : 16'h0000;

endmodule
